// File: rtl/particle_contact_resolver_2d_assert.svh
// Assertion macros used by the port-level checker of the contact resolver.
`ifndef PARTICLE_CONTACT_RESOLVER_2D_ASSERT_SVH
`define PARTICLE_CONTACT_RESOLVER_2D_ASSERT_SVH

// Clocked assertion that is switched off while reset is applied.
`define PCR2D_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define PCR2D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pcr2d_pkg.sv
// Package with the types, constants and helpers of the contact resolver.
package pcr2d_pkg;

  localparam int unsigned PRE_STAGES = 4;
  localparam int unsigned DIV_STEPS = 25;
  localparam int unsigned POST_STAGES = 3;
  localparam int unsigned NUM_STAGES = PRE_STAGES + DIV_STEPS + POST_STAGES;
  localparam int unsigned DIV_BASE = PRE_STAGES;
  localparam int unsigned MUL_STAGE = DIV_BASE + DIV_STEPS;

  localparam logic [16:0] RESTITUTION_RESET = 17'd32768;
  localparam logic [17:0] E_ONE = 18'd65536;
  localparam logic [24:0] SHARE_ONE = 25'h1000000;

  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [31:0] pen;
    logic [30:0]        ima;
    logic [31:0]        total;
  } pay_t;

  typedef struct packed {
    pay_t        pay;
    logic        app;
    logic [37:0] dv;
    logic [31:0] rem;
    logic [24:0] q;
  } div_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/particle_contact_resolver_2d.sv
// Top level of the pipelined 2D particle contact resolver.
// One contact enters per cycle while in_stall is low. Four stages form the
// separating velocity and the restitution-scaled speed change, a 25-stage
// restoring divider makes the inverse-mass share one quotient bit per stage,
// and three stages do the share multiplies, normal multiplies and saturating
// adds. A stalled output holds its stage, and empty stages in front of it keep
// filling, so the input is stalled only when every stage holds a transaction.
module particle_contact_resolver_2d (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_vel_a_x,
  input  logic signed [31:0] in_vel_a_y,
  input  logic signed [31:0] in_vel_b_x,
  input  logic signed [31:0] in_vel_b_y,
  input  logic signed [17:0] in_normal_x,
  input  logic signed [17:0] in_normal_y,
  input  logic signed [31:0] in_penetration,
  input  logic [30:0]        in_inv_mass_a,
  input  logic [30:0]        in_inv_mass_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_new_vel_a_x,
  output logic signed [31:0] out_new_vel_a_y,
  output logic signed [31:0] out_new_vel_b_x,
  output logic signed [31:0] out_new_vel_b_y,
  output logic signed [31:0] out_pos_delta_a_x,
  output logic signed [31:0] out_pos_delta_a_y,
  output logic signed [31:0] out_pos_delta_b_x,
  output logic signed [31:0] out_pos_delta_b_y,
  output logic               out_impulse_applied,
  output logic               out_moved,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [16:0]        cfg_data
);
  import pcr2d_pkg::*;

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] rdy;
  logic [16:0]           restitution_r;

  pay_t               b0_r, b1_r, b2_r, b3_r;
  logic signed [32:0] dx0_r, dy0_r;
  logic signed [50:0] px1_r, py1_r;
  logic signed [51:0] sum2;
  logic signed [35:0] sep2_r;
  logic [35:0]        negsep;
  logic               app3_r;
  logic [53:0]        dvp3_r;
  logic [17:0]        e_scale;
  div_t               d_r [DIV_STEPS];

  div_t               last;
  logic               nz;
  logic               pen_pos;
  logic [24:0]        fa, fb;
  logic [30:0]        pen_mag;
  pay_t               pay1_r;
  logic               app1_r, mov1_r;
  logic [62:0]        pa1_r, pb1_r;
  logic [55:0]        qa1_r, qb1_r;

  pay_t               pay2_r;
  logic               app2_r, mov2_r;
  logic signed [57:0] xax2_r, xay2_r, xbx2_r, xby2_r;
  logic signed [49:0] yax2_r, yay2_r, ybx2_r, yby2_r;

  logic signed [31:0] nvax_r, nvay_r, nvbx_r, nvby_r;
  logic signed [31:0] dax_r, day_r, dbx_r, dby_r;
  logic               app_r, mov_r;

  always_comb begin
    rdy[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r           <= '0;
      restitution_r <= RESTITUTION_RESET;
    end else begin
      if (cfg_valid) begin
        restitution_r <= cfg_data;
      end
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      b0_r.vax   <= in_vel_a_x;
      b0_r.vay   <= in_vel_a_y;
      b0_r.vbx   <= in_vel_b_x;
      b0_r.vby   <= in_vel_b_y;
      b0_r.nx    <= in_normal_x;
      b0_r.ny    <= in_normal_y;
      b0_r.pen   <= in_penetration;
      b0_r.ima   <= in_inv_mass_a;
      b0_r.total <= {1'b0, in_inv_mass_a} + {1'b0, in_inv_mass_b};
      dx0_r <= $signed({in_vel_b_x[31], in_vel_b_x}) - $signed({in_vel_a_x[31], in_vel_a_x});
      dy0_r <= $signed({in_vel_b_y[31], in_vel_b_y}) - $signed({in_vel_a_y[31], in_vel_a_y});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      b1_r  <= b0_r;
      px1_r <= dx0_r * $signed(b0_r.nx);
      py1_r <= dy0_r * $signed(b0_r.ny);
    end
  end

  assign sum2 = $signed({px1_r[50], px1_r}) + $signed({py1_r[50], py1_r});

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      b2_r   <= b1_r;
      sep2_r <= sum2[51:16];
    end
  end

  assign negsep  = (sep2_r[35] || sep2_r == '0) ? 36'(-sep2_r) : '0;
  assign e_scale = E_ONE + {1'b0, restitution_r};

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      b3_r   <= b2_r;
      app3_r <= sep2_r[35] || sep2_r == '0;
      dvp3_r <= negsep * e_scale;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    div_t        src;
    logic [32:0] t;
    logic        ge;

    if (j == 0) begin : g_first
      always_comb begin
        src.pay = b3_r;
        src.app = app3_r;
        src.dv  = dvp3_r[53:16];
        src.rem = '0;
        src.q   = '0;
      end
      assign t = {2'b00, src.pay.ima};
    end else begin : g_next
      assign src = d_r[j-1];
      assign t   = {src.rem, 1'b0};
    end

    assign ge = t >= {1'b0, src.pay.total};

    always_ff @(posedge clk) begin
      if (rdy[DIV_BASE+j]) begin
        d_r[j].pay <= src.pay;
        d_r[j].app <= src.app;
        d_r[j].dv  <= src.dv;
        d_r[j].rem <= ge ? 32'(t - {1'b0, src.pay.total}) : t[31:0];
        d_r[j].q   <= {src.q[23:0], ge};
      end
    end
  end

  assign last    = d_r[DIV_STEPS-1];
  assign nz      = last.pay.total != '0;
  assign pen_pos = !last.pay.pen[31] && last.pay.pen != '0;
  assign fa      = last.q;
  assign fb      = SHARE_ONE - fa - 25'(last.rem != '0);
  assign pen_mag = pen_pos ? last.pay.pen[30:0] : '0;

  always_ff @(posedge clk) begin
    if (rdy[MUL_STAGE]) begin
      pay1_r <= last.pay;
      app1_r <= last.app && nz;
      mov1_r <= pen_pos && nz;
      pa1_r  <= last.dv * fa;
      pb1_r  <= last.dv * fb;
      qa1_r  <= pen_mag * fa;
      qb1_r  <= pen_mag * fb;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[MUL_STAGE+1]) begin
      pay2_r <= pay1_r;
      app2_r <= app1_r;
      mov2_r <= mov1_r;
      xax2_r <= $signed(pay1_r.nx) * $signed({1'b0, pa1_r[62:24]});
      xay2_r <= $signed(pay1_r.ny) * $signed({1'b0, pa1_r[62:24]});
      xbx2_r <= $signed(pay1_r.nx) * $signed({1'b0, pb1_r[62:24]});
      xby2_r <= $signed(pay1_r.ny) * $signed({1'b0, pb1_r[62:24]});
      yax2_r <= $signed(pay1_r.nx) * $signed({1'b0, qa1_r[54:24]});
      yay2_r <= $signed(pay1_r.ny) * $signed({1'b0, qa1_r[54:24]});
      ybx2_r <= $signed(pay1_r.nx) * $signed({1'b0, qb1_r[54:24]});
      yby2_r <= $signed(pay1_r.ny) * $signed({1'b0, qb1_r[54:24]});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NUM_STAGES-1]) begin
      app_r <= app2_r;
      mov_r <= mov2_r;
      if (app2_r) begin
        nvax_r <= sat32(64'(pay2_r.vax) + ((-64'(xax2_r)) >>> 16));
        nvay_r <= sat32(64'(pay2_r.vay) + ((-64'(xay2_r)) >>> 16));
        nvbx_r <= sat32(64'(pay2_r.vbx) + (64'(xbx2_r) >>> 16));
        nvby_r <= sat32(64'(pay2_r.vby) + (64'(xby2_r) >>> 16));
      end else begin
        nvax_r <= pay2_r.vax;
        nvay_r <= pay2_r.vay;
        nvbx_r <= pay2_r.vbx;
        nvby_r <= pay2_r.vby;
      end
      if (mov2_r) begin
        dax_r <= sat32((-64'(yax2_r)) >>> 16);
        day_r <= sat32((-64'(yay2_r)) >>> 16);
        dbx_r <= sat32(64'(ybx2_r) >>> 16);
        dby_r <= sat32(64'(yby2_r) >>> 16);
      end else begin
        dax_r <= '0;
        day_r <= '0;
        dbx_r <= '0;
        dby_r <= '0;
      end
    end
  end

  assign out_valid           = v_r[NUM_STAGES-1];
  assign out_new_vel_a_x     = nvax_r;
  assign out_new_vel_a_y     = nvay_r;
  assign out_new_vel_b_x     = nvbx_r;
  assign out_new_vel_b_y     = nvby_r;
  assign out_pos_delta_a_x   = dax_r;
  assign out_pos_delta_a_y   = day_r;
  assign out_pos_delta_b_x   = dbx_r;
  assign out_pos_delta_b_y   = dby_r;
  assign out_impulse_applied = app_r;
  assign out_moved           = mov_r;

endmodule

// File: rtl/pcr2d_checker.sv
// Port-level checker of the contact resolver and its bind statement.
`include "particle_contact_resolver_2d_assert.svh"

module pcr2d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_pos_delta_a_x,
  input logic [31:0] out_pos_delta_a_y,
  input logic [31:0] out_pos_delta_b_x,
  input logic [31:0] out_pos_delta_b_y,
  input logic        out_moved
);

  // A stalled result transaction stays offered.
  `PCR2D_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped")

  // A contact without correction reports zero position deltas.
  `PCR2D_ASSERT(a_no_move, clk, rst_n, out_valid && !out_moved |-> out_pos_delta_a_x == '0 && out_pos_delta_a_y == '0 && out_pos_delta_b_x == '0 && out_pos_delta_b_y == '0, "nonzero delta without move")

  // Reset empties the pipeline.
  `PCR2D_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "valid after reset")

endmodule

bind particle_contact_resolver_2d pcr2d_checker u_pcr2d_checker (.*);

// File: verif/particle_contact_resolver_2d_checker.sv
// Checker that predicts and compares every result of the contact resolver.
`timescale 1ns / 100ps
module particle_contact_resolver_2d_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_vel_a_x,
  input  logic signed [31:0] in_vel_a_y,
  input  logic signed [31:0] in_vel_b_x,
  input  logic signed [31:0] in_vel_b_y,
  input  logic signed [17:0] in_normal_x,
  input  logic signed [17:0] in_normal_y,
  input  logic signed [31:0] in_penetration,
  input  logic [30:0]        in_inv_mass_a,
  input  logic [30:0]        in_inv_mass_b,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_new_vel_a_x,
  input  logic signed [31:0] out_new_vel_a_y,
  input  logic signed [31:0] out_new_vel_b_x,
  input  logic signed [31:0] out_new_vel_b_y,
  input  logic signed [31:0] out_pos_delta_a_x,
  input  logic signed [31:0] out_pos_delta_a_y,
  input  logic signed [31:0] out_pos_delta_b_x,
  input  logic signed [31:0] out_pos_delta_b_y,
  input  logic               out_impulse_applied,
  input  logic               out_moved,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [16:0]        cfg_data,
  output int                 fail_count,
  output int                 due_count
);
  typedef struct packed {
    logic [31:0] nvax;
    logic [31:0] nvay;
    logic [31:0] nvbx;
    logic [31:0] nvby;
    logic [31:0] dax;
    logic [31:0] day;
    logic [31:0] dbx;
    logic [31:0] dby;
    logic        applied;
    logic        moved;
  } contact_res_t;

  contact_res_t resolved_due[$];
  logic [16:0]  restitution;

  function automatic logic [31:0] clamp32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic contact_res_t resolve_contact(
    input logic signed [31:0] vax_i, vay_i, vbx_i, vby_i,
    input logic signed [17:0] nx_i, ny_i,
    input logic signed [31:0] pen_i,
    input logic [30:0] ima_i, imb_i,
    input logic [16:0] e_i
  );
    logic signed [63:0] vax, vay, vbx, vby, nx, ny, pen, ev;
    logic signed [63:0] fa, fb, sep, dv, mag_a, mag_b, ma, mb;
    logic [63:0] total, ima, imb;
    logic signed [63:0] nvax, nvay, nvbx, nvby, dax, day, dbx, dby;
    contact_res_t r;
    vax = vax_i; vay = vay_i; vbx = vbx_i; vby = vby_i;
    nx = nx_i; ny = ny_i; pen = pen_i;
    ima = ima_i; imb = imb_i; total = ima + imb;
    nvax = vax; nvay = vay; nvbx = vbx; nvby = vby;
    dax = 0; day = 0; dbx = 0; dby = 0;
    r.applied = 1'b0;
    r.moved = 1'b0;
    if (total != 0) begin
      fa = (ima << 24) / total;
      fb = (imb << 24) / total;
      sep = ((vbx - vax) * nx + (vby - vay) * ny) >>> 16;
      if (sep <= 0) begin
        ev = 64'sd65536 + e_i;
        dv = ((-sep) * ev) >>> 16;
        mag_a = (dv * fa) >>> 24;
        mag_b = (dv * fb) >>> 24;
        nvax = vax + ((-(nx * mag_a)) >>> 16);
        nvay = vay + ((-(ny * mag_a)) >>> 16);
        nvbx = vbx + ((nx * mag_b) >>> 16);
        nvby = vby + ((ny * mag_b) >>> 16);
        r.applied = 1'b1;
      end
      if (pen > 0) begin
        ma = (pen * fa) >>> 24;
        mb = (pen * fb) >>> 24;
        dax = (-(nx * ma)) >>> 16;
        day = (-(ny * ma)) >>> 16;
        dbx = (nx * mb) >>> 16;
        dby = (ny * mb) >>> 16;
        r.moved = 1'b1;
      end
    end
    r.nvax = clamp32(nvax); r.nvay = clamp32(nvay);
    r.nvbx = clamp32(nvbx); r.nvby = clamp32(nvby);
    r.dax = clamp32(dax); r.day = clamp32(day);
    r.dbx = clamp32(dbx); r.dby = clamp32(dby);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    due_count = 0;
    restitution = 17'd32768;
  end

  always @(posedge clk) begin
    contact_res_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) restitution = cfg_data;
      if (in_valid && !in_stall)
        resolved_due.push_back(resolve_contact(in_vel_a_x, in_vel_a_y, in_vel_b_x,
          in_vel_b_y, in_normal_x, in_normal_y, in_penetration, in_inv_mass_a,
          in_inv_mass_b, restitution));
      if (out_valid && !out_stall) begin
        if (resolved_due.size() == 0) begin
          $error("Result transaction arrived with none expected.");
          fail_count++;
        end else begin
          want = resolved_due.pop_front();
          check_field("new_vel_a_x", want.nvax, out_new_vel_a_x);
          check_field("new_vel_a_y", want.nvay, out_new_vel_a_y);
          check_field("new_vel_b_x", want.nvbx, out_new_vel_b_x);
          check_field("new_vel_b_y", want.nvby, out_new_vel_b_y);
          check_field("pos_delta_a_x", want.dax, out_pos_delta_a_x);
          check_field("pos_delta_a_y", want.day, out_pos_delta_a_y);
          check_field("pos_delta_b_x", want.dbx, out_pos_delta_b_x);
          check_field("pos_delta_b_y", want.dby, out_pos_delta_b_y);
          check_field("impulse_applied", want.applied, out_impulse_applied);
          check_field("moved", want.moved, out_moved);
        end
      end
      due_count = resolved_due.size();
    end
  end
endmodule

// File: verif/particle_contact_resolver_2d_test.sv
// Testbench top that drives contacts and configuration into the contact resolver.
`timescale 1ns / 100ps
module particle_contact_resolver_2d_test;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_vel_a_x = '0, in_vel_a_y = '0, in_vel_b_x = '0, in_vel_b_y = '0;
  logic signed [17:0] in_normal_x = '0, in_normal_y = '0;
  logic signed [31:0] in_penetration = '0;
  logic [30:0] in_inv_mass_a = '0, in_inv_mass_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_new_vel_a_x, out_new_vel_a_y, out_new_vel_b_x, out_new_vel_b_y;
  logic signed [31:0] out_pos_delta_a_x, out_pos_delta_a_y;
  logic signed [31:0] out_pos_delta_b_x, out_pos_delta_b_y;
  logic out_impulse_applied, out_moved;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [16:0] cfg_data = '0;
  int fail_count, due_count;
  int hold_off_cycles = 0;
  bit rush_results = 1'b0;
  int quiet_cycles = 0;

  localparam int QUIET_LIMIT = 5000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  particle_contact_resolver_2d uut (.*);
  particle_contact_resolver_2d_checker checker_i (.*);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: a random stall per transaction, or a long hold when asked.
  initial begin
    int wait_left;
    wait_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles--;
      end else if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
        if (out_valid && !out_stall) wait_left = rush_results ? 0 : $urandom_range(0, 14);
      end
    end
  end

  task automatic send_contact(input logic [31:0] vax, vay, vbx, vby,
                              input logic [17:0] nx, ny, input logic [31:0] pen,
                              input logic [30:0] ima, imb, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_vel_a_x <= vax; in_vel_a_y <= vay; in_vel_b_x <= vbx; in_vel_b_y <= vby;
    in_normal_x <= nx; in_normal_y <= ny; in_penetration <= pen;
    in_inv_mass_a <= ima; in_inv_mass_b <= imb;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_count != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_restitution(input logic [16:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_speed();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  function automatic logic [17:0] pick_normal();
    case ($urandom_range(0, 4))
      0: return 18'($urandom);
      1: return $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic [30:0] pick_inv_mass();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 31'($urandom);
      2: return 31'h7fffffff;
      default: return 31'($urandom_range(1, 1 << 20));
    endcase
  endfunction

  task automatic send_random(input int gap);
    logic [31:0] pen;
    pen = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 1 << 20));
    send_contact(pick_speed(), pick_speed(), pick_speed(), pick_speed(),
                 pick_normal(), pick_normal(), pen, pick_inv_mass(), pick_inv_mass(), gap);
  endtask

  initial begin
    logic [16:0] settings [4];
    int n, burst;
    settings[0] = 17'd0;
    settings[1] = 17'd65536;
    settings[2] = 17'h1ffff;
    settings[3] = 17'($urandom_range(1, 65535));
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed contacts under the reset restitution.
    send_contact(32'h00010000, 0, 32'hffff0000, 0, 18'sd65536, 0, 32'h8000,
                 31'h10000, 31'h10000, 0);
    send_contact(0, 0, 32'h00010000, 0, 18'sd65536, 0, 32'h8000, 31'h10000, 31'h10000, 0);
    send_contact(32'h00020000, 0, 32'h00020000, 0, 18'sd65536, 0, 0, 31'h10000, 31'h20000, 0);
    send_contact(32'h00010000, 0, 0, 0, 18'sd65536, 0, 32'h10000, 0, 0, 0);
    send_contact(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 18'sd65536,
                 18'sd65536, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff, 0);
    send_contact(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, -18'sd65536,
                 -18'sd65536, 32'h7fffffff, 31'h1, 31'h7fffffff, 0);
    send_contact(32'h7fffffff, 0, 32'h80000000, 0, 18'h1ffff, 18'h20000, 32'h80000000,
                 31'h7fffffff, 0, 0);
    send_contact(0, 32'h00050000, 0, 32'hfffb0000, 0, -18'sd65536, 32'hffffffff,
                 0, 31'h10000, 0);
    send_contact(32'h00030000, 32'h00010000, 0, 0, 18'sd46341, 18'sd46341, 1, 31'h1,
                 31'h1, 0);
    send_contact(0, 0, 0, 0, 0, 0, 32'h00010000, 31'h8000, 31'h18000, 0);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_restitution(settings[p]);
      n = 0;
      while (n < 350) begin
        burst = $urandom_range(5, 40);
        rush_results = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < burst; i++) begin
          if ((burst & 1) == 1) send_random(0);
          else send_random($urandom_range(0, 14));
          n++;
        end
        if (p == 1 && n >= 100 && n < 150) hold_off_cycles = 300;
        if (p == 2 && n >= 100 && n < 150) drain();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
